FILE: hdl/bole_pkg.sv
// Shared types, constants and value conversions for the bounded ordered list engine.
// Used by bole_store, bole_walk and bounded_ordered_list_engine.
`default_nettype none
package bole_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int OP_W   = 4;
  localparam int IO_W   = 32;
  localparam int POS_IN_W = 8;
  localparam int ST_W   = 3;
  localparam int POS_W  = 7;

  localparam logic [OP_W-1:0] OP_INS_FRONT  = 4'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR   = 4'd1;
  localparam logic [OP_W-1:0] OP_INS_AT     = 4'd2;
  localparam logic [OP_W-1:0] OP_DEL_FRONT  = 4'd3;
  localparam logic [OP_W-1:0] OP_DEL_REAR   = 4'd4;
  localparam logic [OP_W-1:0] OP_DEL_AT     = 4'd5;
  localparam logic [OP_W-1:0] OP_DEL_KEY    = 4'd6;
  localparam logic [OP_W-1:0] OP_SEARCH     = 4'd7;
  localparam logic [OP_W-1:0] OP_INS_SORTED = 4'd8;
  localparam logic [OP_W-1:0] OP_REVERSE    = 4'd9;
  localparam logic [OP_W-1:0] OP_DUMP       = 4'd10;

  localparam logic [ST_W-1:0] ST_OK       = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
  localparam logic [ST_W-1:0] ST_INVALID  = 3'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL     = 3'd4;

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             cnt_t;

  typedef struct packed {
    logic [OP_W-1:0]     operation;
    logic [IO_W-1:0]     value;
    logic [POS_IN_W-1:0] position;
    logic [IO_W-1:0]     key;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [POS_W-1:0] found_position;
    logic [IO_W-1:0]  entry_value;
    logic [POS_W-1:0] entry_count;
    logic             last;
  } res_t;

  function automatic data_t from_input(input logic [IO_W-1:0] raw);
    logic signed [IO_W-1:0] s;
    s = signed'(raw);
    return data_t'(s);
  endfunction

  function automatic logic [IO_W-1:0] to_output(input data_t d);
    logic signed [IO_W-1:0] s;
    s = IO_W'(d);
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/bole_store.sv
// Entry store: one write port and one read port with registered read data.
// Depends on bole_pkg.
`default_nettype none
module bole_store (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire bole_pkg::addr_t wa,
  input  wire bole_pkg::data_t wd,
  input  wire logic           re,
  input  wire bole_pkg::addr_t ra,
  output bole_pkg::data_t     rd
);

  bole_pkg::data_t mem [bole_pkg::DEPTH];
  bole_pkg::data_t rd_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rd_r <= mem[ra];
    end
  end

  assign rd = rd_r;

endmodule
`default_nettype wire

FILE: hdl/bole_walk.sv
// Sequencer that walks the entry store step by step with a shared compare unit.
// Depends on bole_pkg and bole_store.
`default_nettype none
module bole_walk (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire bole_pkg::req_t req,
  input  wire logic           res_ready,
  output logic                idle,
  output logic                res_valid,
  output bole_pkg::res_t      res
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SR_RD  = 4'd1;
  localparam logic [3:0] S_SR_WR  = 4'd2;
  localparam logic [3:0] S_SL_RD  = 4'd3;
  localparam logic [3:0] S_SL_WR  = 4'd4;
  localparam logic [3:0] S_SC_RD  = 4'd5;
  localparam logic [3:0] S_SC_CHK = 4'd6;
  localparam logic [3:0] S_RV_RD1 = 4'd7;
  localparam logic [3:0] S_RV_RD2 = 4'd8;
  localparam logic [3:0] S_RV_WR1 = 4'd9;
  localparam logic [3:0] S_RV_WR2 = 4'd10;
  localparam logic [3:0] S_DP_RD  = 4'd11;
  localparam logic [3:0] S_DP_EM  = 4'd12;
  localparam logic [3:0] S_RES    = 4'd13;

  localparam int PW = bole_pkg::POS_IN_W + 1;

  logic [3:0]                    state_r, state_nxt;
  logic [bole_pkg::OP_W-1:0]     op_r, op_nxt;
  bole_pkg::data_t               val_r, val_nxt;
  bole_pkg::data_t               key_r, key_nxt;
  bole_pkg::data_t               tmp_r, tmp_nxt;
  bole_pkg::cnt_t                i_r, i_nxt;
  bole_pkg::cnt_t                j_r, j_nxt;
  bole_pkg::cnt_t                occ_r, occ_nxt;
  logic [bole_pkg::ST_W-1:0]     st_r, st_nxt;
  logic [bole_pkg::POS_W-1:0]    fpos_r, fpos_nxt;

  logic             we, re;
  bole_pkg::addr_t  wa, ra;
  bole_pkg::data_t  wd, rd;

  logic             full, empty, hit, cmp_eq, cmp_lt;
  logic [PW-1:0]    pos_x, occ_x;
  bole_pkg::cnt_t   i_inc, pos_dec;

  bole_store u_store (
    .clk (clk),
    .we  (we),
    .wa  (wa),
    .wd  (wd),
    .re  (re),
    .ra  (ra),
    .rd  (rd)
  );

  assign full    = (occ_r == bole_pkg::cnt_t'(bole_pkg::DEPTH));
  assign empty   = (occ_r == '0);
  assign pos_x   = PW'(req.position);
  assign occ_x   = PW'(occ_r);
  assign pos_dec = bole_pkg::cnt_t'(pos_x - 1'b1);
  assign i_inc   = i_r + 1'b1;
  assign cmp_eq  = (rd == key_r);
  assign cmp_lt  = (rd < val_r);
  assign hit     = (op_r == bole_pkg::OP_INS_SORTED) ? !cmp_lt : cmp_eq;
  assign idle    = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    val_nxt   = val_r;
    key_nxt   = key_r;
    tmp_nxt   = tmp_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    occ_nxt   = occ_r;
    st_nxt    = st_r;
    fpos_nxt  = fpos_r;
    we        = 1'b0;
    re        = 1'b0;
    wa        = '0;
    ra        = '0;
    wd        = val_r;
    res_valid = 1'b0;
    res.status         = st_r;
    res.found_position = fpos_r;
    res.entry_value    = '0;
    res.entry_count    = bole_pkg::POS_W'(occ_r);
    res.last           = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt   = req.operation;
          val_nxt  = bole_pkg::from_input(req.value);
          key_nxt  = bole_pkg::from_input(req.key);
          st_nxt   = bole_pkg::ST_OK;
          fpos_nxt = '0;
          i_nxt    = '0;
          j_nxt    = '0;
          state_nxt = S_RES;
          case (req.operation)
            bole_pkg::OP_INS_FRONT: begin
              if (full) st_nxt = bole_pkg::ST_FULL;
              else begin
                i_nxt = occ_r;
                state_nxt = S_SR_RD;
              end
            end
            bole_pkg::OP_INS_REAR: begin
              if (full) st_nxt = bole_pkg::ST_FULL;
              else begin
                i_nxt = occ_r;
                j_nxt = occ_r;
                state_nxt = S_SR_RD;
              end
            end
            bole_pkg::OP_INS_AT: begin
              if (pos_x == '0 || pos_x > occ_x + 1'b1) st_nxt = bole_pkg::ST_INVALID;
              else if (full) st_nxt = bole_pkg::ST_FULL;
              else begin
                i_nxt = occ_r;
                j_nxt = pos_dec;
                state_nxt = S_SR_RD;
              end
            end
            bole_pkg::OP_DEL_FRONT: begin
              if (empty) st_nxt = bole_pkg::ST_EMPTY;
              else state_nxt = S_SL_RD;
            end
            bole_pkg::OP_DEL_REAR: begin
              if (empty) st_nxt = bole_pkg::ST_EMPTY;
              else begin
                i_nxt = occ_r - 1'b1;
                state_nxt = S_SL_RD;
              end
            end
            bole_pkg::OP_DEL_AT: begin
              if (empty) st_nxt = bole_pkg::ST_EMPTY;
              else if (pos_x == '0 || pos_x > occ_x) st_nxt = bole_pkg::ST_INVALID;
              else begin
                i_nxt = pos_dec;
                state_nxt = S_SL_RD;
              end
            end
            bole_pkg::OP_DEL_KEY, bole_pkg::OP_SEARCH: begin
              if (empty) st_nxt = bole_pkg::ST_EMPTY;
              else state_nxt = S_SC_RD;
            end
            bole_pkg::OP_INS_SORTED: begin
              if (full) st_nxt = bole_pkg::ST_FULL;
              else state_nxt = S_SC_RD;
            end
            bole_pkg::OP_REVERSE: begin
              if (empty) st_nxt = bole_pkg::ST_EMPTY;
              else begin
                j_nxt = occ_r - 1'b1;
                state_nxt = S_RV_RD1;
              end
            end
            bole_pkg::OP_DUMP: begin
              if (empty) st_nxt = bole_pkg::ST_EMPTY;
              else state_nxt = S_DP_RD;
            end
            default: begin
              st_nxt = bole_pkg::ST_OK;
            end
          endcase
        end
      end
      S_SR_RD: begin
        if (i_r > j_r) begin
          re = 1'b1;
          ra = bole_pkg::addr_t'(i_r - 1'b1);
          state_nxt = S_SR_WR;
        end else begin
          we = 1'b1;
          wa = bole_pkg::addr_t'(j_r);
          wd = val_r;
          occ_nxt = occ_r + 1'b1;
          state_nxt = S_RES;
        end
      end
      S_SR_WR: begin
        we = 1'b1;
        wa = bole_pkg::addr_t'(i_r);
        wd = rd;
        i_nxt = i_r - 1'b1;
        state_nxt = S_SR_RD;
      end
      S_SL_RD: begin
        if (i_inc < occ_r) begin
          re = 1'b1;
          ra = bole_pkg::addr_t'(i_inc);
          state_nxt = S_SL_WR;
        end else begin
          occ_nxt = occ_r - 1'b1;
          state_nxt = S_RES;
        end
      end
      S_SL_WR: begin
        we = 1'b1;
        wa = bole_pkg::addr_t'(i_r);
        wd = rd;
        i_nxt = i_inc;
        state_nxt = S_SL_RD;
      end
      S_SC_RD: begin
        if (i_r < occ_r) begin
          re = 1'b1;
          ra = bole_pkg::addr_t'(i_r);
          state_nxt = S_SC_CHK;
        end else if (op_r == bole_pkg::OP_INS_SORTED) begin
          j_nxt = occ_r;
          i_nxt = occ_r;
          state_nxt = S_SR_RD;
        end else begin
          st_nxt = bole_pkg::ST_NOTFOUND;
          state_nxt = S_RES;
        end
      end
      S_SC_CHK: begin
        if (hit) begin
          case (op_r)
            bole_pkg::OP_DEL_KEY: begin
              state_nxt = S_SL_RD;
            end
            bole_pkg::OP_INS_SORTED: begin
              j_nxt = i_r;
              i_nxt = occ_r;
              state_nxt = S_SR_RD;
            end
            default: begin
              fpos_nxt = bole_pkg::POS_W'(i_inc);
              state_nxt = S_RES;
            end
          endcase
        end else begin
          i_nxt = i_inc;
          state_nxt = S_SC_RD;
        end
      end
      S_RV_RD1: begin
        if (i_r < j_r) begin
          re = 1'b1;
          ra = bole_pkg::addr_t'(i_r);
          state_nxt = S_RV_RD2;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RV_RD2: begin
        re = 1'b1;
        ra = bole_pkg::addr_t'(j_r);
        tmp_nxt = rd;
        state_nxt = S_RV_WR1;
      end
      S_RV_WR1: begin
        we = 1'b1;
        wa = bole_pkg::addr_t'(i_r);
        wd = rd;
        state_nxt = S_RV_WR2;
      end
      S_RV_WR2: begin
        we = 1'b1;
        wa = bole_pkg::addr_t'(j_r);
        wd = tmp_r;
        i_nxt = i_inc;
        j_nxt = j_r - 1'b1;
        state_nxt = S_RV_RD1;
      end
      S_DP_RD: begin
        re = 1'b1;
        ra = bole_pkg::addr_t'(i_r);
        state_nxt = S_DP_EM;
      end
      S_DP_EM: begin
        res.status         = bole_pkg::ST_OK;
        res.found_position = bole_pkg::POS_W'(i_inc);
        res.entry_value    = bole_pkg::to_output(rd);
        res.last           = (i_inc == occ_r);
        if (res_ready) begin
          res_valid = 1'b1;
          i_nxt = i_inc;
          state_nxt = (i_inc == occ_r) ? S_IDLE : S_DP_RD;
        end
      end
      S_RES: begin
        if (res_ready) begin
          res_valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      occ_r   <= '0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    key_r  <= key_nxt;
    tmp_r  <= tmp_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    st_r   <= st_nxt;
    fpos_r <= fpos_nxt;
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == S_IDLE)
    else $error("item started while sequencer busy");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= bole_pkg::cnt_t'(bole_pkg::DEPTH))
    else $error("occupancy above depth");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && occ_r != $past(occ_r) |->
      (occ_r == $past(occ_r) + 1'b1 || occ_r == $past(occ_r) - 1'b1))
    else $error("occupancy moved by more than one");

  a_res_ready: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> res_ready)
    else $error("result issued without room");

  a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> bole_pkg::cnt_t'(wa) <= occ_r)
    else $error("write beyond list tail");

endmodule
`default_nettype wire

FILE: hdl/bounded_ordered_list_engine.sv
// Top level of the bounded ordered list engine: input handshake and output register.
// Depends on bole_pkg and bole_walk.
//
// Usage:
//   Input channel in_*: one operation per transfer (operation, value, position, key).
//   Result channel out_*: status, found_position, entry_value, entry_count, last.
//   Every operation gives one result with last set, except a dump of a non-empty
//   list, which gives one result per entry with last set on the final one.
//   in_stall stays high from the transfer until the item's last result has been
//   loaded into the output register; one item is worked on at a time.
//   Latency: the last result shows on out_* in the cycle in which in_stall drops.
//   The sequencer walks the entry store step by step, reading an entry and then writing
//   or checking it: inserts and deletes shift the entries behind the position, search
//   and delete-by-key scan from the front, sorted insert scans and then shifts, reverse
//   swaps pairs from both ends, and a dump reads one entry per result.
//   Reset clears the entry count; the stored values need no clearing.
//   While out_stall is high and a result is held, the output register keeps it and the
//   sequencer waits before issuing the next one.
`default_nettype none
module bounded_ordered_list_engine (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [bole_pkg::OP_W-1:0]         in_operation,
  input  wire logic signed [bole_pkg::IO_W-1:0]  in_value,
  input  wire logic [bole_pkg::POS_IN_W-1:0]     in_position,
  input  wire logic signed [bole_pkg::IO_W-1:0]  in_key,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [bole_pkg::ST_W-1:0]              out_status,
  output logic [bole_pkg::POS_W-1:0]             out_found_position,
  output logic signed [bole_pkg::IO_W-1:0]       out_entry_value,
  output logic [bole_pkg::POS_W-1:0]             out_entry_count,
  output logic                                   out_last
);

  bole_pkg::req_t req;
  bole_pkg::res_t res;
  bole_pkg::res_t res_r;
  logic           out_valid_r;
  logic           walk_idle, start, res_valid, res_ready;

  assign req.operation = in_operation;
  assign req.value     = in_value;
  assign req.position  = in_position;
  assign req.key       = in_key;

  assign in_stall  = !walk_idle;
  assign start     = in_valid && walk_idle;
  assign res_ready = !out_valid_r || !out_stall;

  bole_walk u_walk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .req       (req),
    .res_ready (res_ready),
    .idle      (walk_idle),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = res_r.status;
  assign out_found_position = res_r.found_position;
  assign out_entry_value    = res_r.entry_value;
  assign out_entry_count    = res_r.entry_count;
  assign out_last           = res_r.last;

endmodule
`default_nettype wire

FILE: verif/bounded_ordered_list_engine_test.sv
// Self-checking testbench for bounded_ordered_list_engine: directed and random list operations
// from a bursty sender into a stalling receiver, every result checked against an in-bench list.
// Depends on bole_pkg and the engine RTL; reads no files.
module bounded_ordered_list_engine_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 4 * bole_pkg::DEPTH + 8;
  localparam int RANDOM_ITEMS   = 175;

  localparam logic signed [bole_pkg::IO_W-1:0] WORD_MIN = {1'b1, {(bole_pkg::IO_W-1){1'b0}}};
  localparam logic signed [bole_pkg::IO_W-1:0] WORD_MAX = ~WORD_MIN;

  typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} list_phase_e;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_TOGGLE, STALL_HEAVY} stall_mode_e;

  typedef struct {
    logic [bole_pkg::OP_W-1:0]        operation;
    logic signed [bole_pkg::IO_W-1:0] value;
    logic [bole_pkg::POS_IN_W-1:0]    position;
    logic signed [bole_pkg::IO_W-1:0] key;
    bit                               drain_first;
  } list_request_t;

  typedef struct {
    logic [bole_pkg::ST_W-1:0]        status;
    logic [bole_pkg::POS_W-1:0]       found_position;
    logic signed [bole_pkg::IO_W-1:0] entry_value;
    logic [bole_pkg::POS_W-1:0]       entry_count;
    logic                             last;
  } list_result_t;

  logic                             clk          = 1'b0;
  logic                             rst_n        = 1'b0;
  logic                             in_valid     = 1'b0;
  logic                             in_stall;
  logic [bole_pkg::OP_W-1:0]        in_operation = '0;
  logic signed [bole_pkg::IO_W-1:0] in_value     = '0;
  logic [bole_pkg::POS_IN_W-1:0]    in_position  = '0;
  logic signed [bole_pkg::IO_W-1:0] in_key       = '0;
  logic                             out_valid;
  logic                             out_stall    = 1'b0;
  logic [bole_pkg::ST_W-1:0]        out_status;
  logic [bole_pkg::POS_W-1:0]       out_found_position;
  logic signed [bole_pkg::IO_W-1:0] out_entry_value;
  logic [bole_pkg::POS_W-1:0]       out_entry_count;
  logic                             out_last;

  list_request_t   pending_requests[$];
  list_result_t    expected_results[$];
  bole_pkg::data_t list_entries[bole_pkg::DEPTH];
  int              list_count      = 0;
  int              peak_count      = 0;
  int              error_count     = 0;
  int              items_accepted  = 0;
  int              results_checked = 0;
  int              dumps_seen      = 0;
  int              full_rejects    = 0;
  bit              results_drained = 1'b1;
  int              gap_left        = 0;
  int              burst_left      = 0;
  int              mode_left       = 0;
  int              quiet_cycles    = 0;
  stall_mode_e     stall_mode      = STALL_NONE;

  bounded_ordered_list_engine dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_value          (in_value),
    .in_position       (in_position),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_position(out_found_position),
    .out_entry_value   (out_entry_value),
    .out_entry_count   (out_entry_count),
    .out_last          (out_last)
  );

  always #6 clk = ~clk;

  function automatic void insert_entry(int idx, bole_pkg::data_t word);
    for (int i = list_count; i > idx; i--) list_entries[i] = list_entries[i - 1];
    list_entries[idx] = word;
    list_count++;
    if (list_count > peak_count) peak_count = list_count;
  endfunction

  function automatic void remove_entry(int idx);
    for (int i = idx; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
    list_count--;
  endfunction

  function automatic void predict_operation(list_request_t req);
    bole_pkg::data_t word;
    bole_pkg::data_t probe;
    bole_pkg::data_t swap_word;
    int              hit;
    int              slot;
    bit              is_full;
    bit              is_empty;
    list_result_t    res;
    word     = bole_pkg::data_t'(req.value);
    probe    = bole_pkg::data_t'(req.key);
    is_full  = (list_count >= bole_pkg::DEPTH);
    is_empty = (list_count == 0);
    hit      = -1;
    for (int i = list_count - 1; i >= 0; i--) if (list_entries[i] == probe) hit = i;
    res.status         = bole_pkg::ST_OK;
    res.found_position = '0;
    res.entry_value    = '0;
    res.entry_count    = '0;
    res.last           = 1'b1;
    case (req.operation)
      bole_pkg::OP_INS_FRONT, bole_pkg::OP_INS_REAR: begin
        if (is_full) res.status = bole_pkg::ST_FULL;
        else insert_entry((req.operation == bole_pkg::OP_INS_FRONT) ? 0 : list_count, word);
      end
      bole_pkg::OP_INS_AT: begin
        if (req.position < 1 || req.position > list_count + 1) res.status = bole_pkg::ST_INVALID;
        else if (is_full) res.status = bole_pkg::ST_FULL;
        else insert_entry(int'(req.position) - 1, word);
      end
      bole_pkg::OP_DEL_FRONT, bole_pkg::OP_DEL_REAR: begin
        if (is_empty) res.status = bole_pkg::ST_EMPTY;
        else remove_entry((req.operation == bole_pkg::OP_DEL_FRONT) ? 0 : list_count - 1);
      end
      bole_pkg::OP_DEL_AT: begin
        if (is_empty) res.status = bole_pkg::ST_EMPTY;
        else if (req.position < 1 || req.position > list_count) res.status = bole_pkg::ST_INVALID;
        else remove_entry(int'(req.position) - 1);
      end
      bole_pkg::OP_DEL_KEY, bole_pkg::OP_SEARCH: begin
        if (is_empty) res.status = bole_pkg::ST_EMPTY;
        else if (hit < 0) res.status = bole_pkg::ST_NOTFOUND;
        else if (req.operation == bole_pkg::OP_DEL_KEY) remove_entry(hit);
        else res.found_position = bole_pkg::POS_W'(hit + 1);
      end
      bole_pkg::OP_INS_SORTED: begin
        if (is_full) begin
          res.status = bole_pkg::ST_FULL;
        end else begin
          slot = list_count;
          for (int i = list_count - 1; i >= 0; i--) if (!(list_entries[i] < word)) slot = i;
          insert_entry(slot, word);
        end
      end
      bole_pkg::OP_REVERSE: begin
        if (is_empty) begin
          res.status = bole_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i < list_count / 2; i++) begin
            swap_word = list_entries[i];
            list_entries[i] = list_entries[list_count - 1 - i];
            list_entries[list_count - 1 - i] = swap_word;
          end
        end
      end
      bole_pkg::OP_DUMP: begin
        if (is_empty) begin
          res.status = bole_pkg::ST_EMPTY;
        end else begin
          dumps_seen++;
          for (int i = 0; i < list_count; i++) begin
            res.found_position = bole_pkg::POS_W'(i + 1);
            res.entry_value    = bole_pkg::IO_W'(list_entries[i]);
            res.entry_count    = bole_pkg::POS_W'(list_count);
            res.last           = (i == list_count - 1);
            expected_results.push_back(res);
          end
          return;
        end
      end
      default: ;
    endcase
    if (res.status == bole_pkg::ST_FULL) full_rejects++;
    res.entry_count = bole_pkg::POS_W'(list_count);
    expected_results.push_back(res);
  endfunction

  function automatic void check_field(string field, logic [bole_pkg::IO_W-1:0] want,
                                      logic [bole_pkg::IO_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    end
  endfunction

  function automatic void queue_request(logic [bole_pkg::OP_W-1:0] op_code,
                                        logic signed [bole_pkg::IO_W-1:0] word,
                                        int slot, logic signed [bole_pkg::IO_W-1:0] probe,
                                        bit hold);
    list_request_t req;
    req.operation   = op_code;
    req.value       = word;
    req.position    = bole_pkg::POS_IN_W'(slot);
    req.key         = probe;
    req.drain_first = hold;
    pending_requests.push_back(req);
  endfunction

  function automatic logic signed [bole_pkg::IO_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return WORD_MIN;
      3:       return WORD_MAX;
      default: return bole_pkg::IO_W'(int'($urandom_range(0, 8)) - 4);
    endcase
  endfunction

  function automatic logic [bole_pkg::OP_W-1:0] pick_operation(list_phase_e phase);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      return bole_pkg::OP_W'($urandom_range(bole_pkg::OP_DUMP + 1, (1 << bole_pkg::OP_W) - 1));
    end
    if (phase == PHASE_MIXED) begin
      return bole_pkg::OP_W'($urandom_range(bole_pkg::OP_INS_FRONT, bole_pkg::OP_DUMP));
    end
    if ((phase == PHASE_FILL && roll < 75) || (phase == PHASE_DRAIN && roll < 15)) begin
      case ($urandom_range(0, 3))
        0:       return bole_pkg::OP_INS_FRONT;
        1:       return bole_pkg::OP_INS_REAR;
        2:       return bole_pkg::OP_INS_AT;
        default: return bole_pkg::OP_INS_SORTED;
      endcase
    end
    if ((phase == PHASE_FILL) ? roll < 80 : roll < 75) begin
      case ($urandom_range(0, 3))
        0:       return bole_pkg::OP_DEL_FRONT;
        1:       return bole_pkg::OP_DEL_REAR;
        2:       return bole_pkg::OP_DEL_AT;
        default: return bole_pkg::OP_DEL_KEY;
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return bole_pkg::OP_SEARCH;
      1:       return bole_pkg::OP_REVERSE;
      default: return bole_pkg::OP_DUMP;
    endcase
  endfunction

  always @(posedge clk) begin : request_driver
    if (rst_n && (!in_valid || !in_stall)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_requests.size() > 0 &&
                   !(pending_requests[0].drain_first && (in_valid || !results_drained))) begin
        in_valid     <= 1'b1;
        in_operation <= pending_requests[0].operation;
        in_value     <= pending_requests[0].value;
        in_position  <= pending_requests[0].position;
        in_key       <= pending_requests[0].key;
        void'(pending_requests.pop_front());
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_backpressure
    if (rst_n) begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_SPARSE: out_stall <= ($urandom_range(0, 4) == 0);
        STALL_TOGGLE: out_stall <= ~out_stall;
        default:      out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : result_monitor
    list_result_t  want;
    list_request_t taken;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected transfer, expected none, actual status %0d value %h last %b",
                   $time, out_status, out_entry_value, out_last);
        end else begin
          want = expected_results.pop_front();
          results_checked++;
          check_field("status", bole_pkg::IO_W'(want.status), bole_pkg::IO_W'(out_status));
          check_field("found_position", bole_pkg::IO_W'(want.found_position),
                      bole_pkg::IO_W'(out_found_position));
          check_field("entry_value", want.entry_value, out_entry_value);
          check_field("entry_count", bole_pkg::IO_W'(want.entry_count),
                      bole_pkg::IO_W'(out_entry_count));
          check_field("last", bole_pkg::IO_W'(want.last), bole_pkg::IO_W'(out_last));
        end
      end
      if (in_valid && !in_stall) begin
        taken.operation   = in_operation;
        taken.value       = in_value;
        taken.position    = in_position;
        taken.key         = in_key;
        taken.drain_first = 1'b0;
        predict_operation(taken);
        items_accepted++;
      end
    end
  end

  always @(negedge clk) results_drained <= (expected_results.size() == 0);

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    list_phase_e phase;
    int          span;
    int          produced;

    queue_request(bole_pkg::OP_DEL_FRONT, $urandom, 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DEL_REAR, $urandom, 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DEL_AT, $urandom, 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DEL_KEY, $urandom, 1, 0, 1'b0);
    queue_request(bole_pkg::OP_SEARCH, $urandom, 1, 0, 1'b0);
    queue_request(bole_pkg::OP_REVERSE, $urandom, 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DUMP, $urandom, 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_AT, 5, 0, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_AT, 5, 2, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_AT, WORD_MAX, 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_FRONT, WORD_MIN, $urandom, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_REAR, 0, $urandom, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_SORTED, -1, $urandom, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_AT, 9, (1 << bole_pkg::POS_IN_W) - 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_INS_AT, 7, 5, $urandom, 1'b0);
    queue_request(bole_pkg::OP_SEARCH, $urandom, $urandom, WORD_MAX, 1'b0);
    queue_request(bole_pkg::OP_SEARCH, $urandom, $urandom, 12345, 1'b0);
    queue_request(bole_pkg::OP_DEL_KEY, $urandom, $urandom, 12345, 1'b0);
    queue_request(bole_pkg::OP_DEL_AT, $urandom, 0, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DEL_AT, $urandom, (1 << bole_pkg::POS_IN_W) - 1, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DEL_AT, $urandom, 5, $urandom, 1'b0);
    queue_request(bole_pkg::OP_REVERSE, $urandom, $urandom, $urandom, 1'b0);
    queue_request(bole_pkg::OP_DUMP, $urandom, $urandom, $urandom, 1'b0);
    queue_request(bole_pkg::OP_W'((1 << bole_pkg::OP_W) - 1), $urandom, $urandom, $urandom,
                  1'b0);
    queue_request(bole_pkg::OP_DEL_KEY, $urandom, $urandom, WORD_MIN, 1'b0);

    produced = 0;
    phase    = PHASE_FILL;
    span     = 30;
    while (produced < RANDOM_ITEMS) begin
      repeat (span) begin
        if (produced < RANDOM_ITEMS) begin
          queue_request(pick_operation(phase), pick_word(),
                        ($urandom_range(0, 3) == 0)
                          ? $urandom_range(0, (1 << bole_pkg::POS_IN_W) - 1)
                          : $urandom_range(0, bole_pkg::DEPTH + 2),
                        pick_word(), produced == 0 || $urandom_range(0, 39) == 0);
          produced++;
        end
      end
      phase = list_phase_e'($urandom_range(0, 2));
      span  = $urandom_range(8, 30);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_requests.size() > 0 || in_valid);
    do @(negedge clk); while (expected_results.size() > 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d list operations with %0d non-empty dumps and %0d full rejects;",
             items_accepted, dumps_seen, full_rejects);
    $display("checked %0d results, list grew to %0d of %0d entries.",
             results_checked, peak_count, bole_pkg::DEPTH);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
